@@ rtl/mhpq_pkg.sv @@
// Package for the min-heap priority queue: sizes, status codes and the
// controller state type. No dependencies.
package mhpq_pkg;

    localparam int DEPTH     = 128;
    localparam int KEY_WIDTH = 32;
    localparam int OCC_W     = 8;
    localparam int STAT_W    = 2;

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CHILD_W = IDX_W + 1;

    localparam int IN_DATA_W  = ((KEY_WIDTH + 7) / 8) * 8;
    localparam int OUT_RAW_W  = KEY_WIDTH + STAT_W + OCC_W;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    typedef enum logic [0:0] {
        OP_INSERT  = 1'b0,
        OP_EXTRACT = 1'b1
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_EX_ROOT,
        ST_EX_LAST,
        ST_EX_KEY,
        ST_DN_L,
        ST_DN_R,
        ST_DN_CMP,
        ST_WR,
        ST_DONE
    } t_state;

endpackage

@@ rtl/mhpq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/min_heap_priority_queue.sv @@
// Top level of the min-heap priority queue: sift controller around one heap RAM.
// Depends on mhpq_pkg and mhpq_ram.
//
// Usage:
//   Slave stream: tuser = op (0 insert, 1 extract-min), tdata = key (signed).
//   Master stream: one result item per input item, tdata = min_key, status,
//   occupancy. min_key is 0 for inserts, -1 for an extract on an empty queue.
//   Status 0 ok, 1 extract on empty, 2 insert refused because full.
// Throughput: one item at a time. An insert passes through accept, a parent
//   read and compare per level it climbs, the final write and the result
//   load; a refused insert or an extract on an empty queue goes from accept
//   straight to the result load. An extract reads the root, then the last
//   key, then per level it descends the left child, the right child and a
//   compare, and ends with the final write and the result load; when it
//   takes the last key it skips the sift and the write. Sift-down reads the
//   two children one after the other, as the single RAM read port is registered.
// The sifting key is held in a register and the hole moves through the RAM,
//   so each level costs at most one write.
// Reset: the entry count clears to zero at once; the RAM needs no clearing,
//   as only entries below the count are used.
// Stall: a finished result sits in an output register; the next item is
//   accepted meanwhile, and its result waits in the controller until the
//   register frees up.
module min_heap_priority_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [31:0] key
    input  logic [mhpq_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // [0] op
    input  logic                            i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [31:0] min_key, [33:32] status, [41:34] occupancy, [47:42] zero
    output logic [mhpq_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam int KW = mhpq_pkg::KEY_WIDTH;
    localparam int IW = mhpq_pkg::IDX_W;
    localparam int CW = mhpq_pkg::CNT_W;
    localparam int HW = mhpq_pkg::CHILD_W;

    mhpq_pkg::t_state  r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [IW-1:0]     r_hole, n_hole;
    logic [KW-1:0]     r_key, n_key;
    logic [KW-1:0]     r_child, n_child;
    logic              r_rv, n_rv;
    logic [KW-1:0]     r_min, n_min;
    mhpq_pkg::t_status r_status, n_status;
    logic              r_out_valid, n_out_valid;
    logic [mhpq_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [KW-1:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [KW-1:0] ram_rdata;

    logic          s_accept;
    logic          out_free;
    logic [IW-1:0] parent_idx;
    logic [HW-1:0] left_idx;
    logic [HW-1:0] right_idx;
    logic [HW-1:0] count_ext;
    logic          pick_right;
    logic [KW-1:0] best_key;
    logic [HW-1:0] best_idx;

    mhpq_ram #(
        .WIDTH(KW),
        .DEPTH(mhpq_pkg::DEPTH)
    ) u_heap_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_s_axis_tready = (r_state == mhpq_pkg::ST_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    assign parent_idx = (r_hole - IW'(1)) >> 1;
    assign left_idx   = {r_hole, 1'b1};
    assign right_idx  = left_idx + HW'(1);
    assign count_ext  = HW'(r_count);

    // in the compare state the RAM holds the right child, r_child the left
    assign pick_right = r_rv && ($signed(ram_rdata) < $signed(r_child));
    assign best_key   = pick_right ? ram_rdata : r_child;
    assign best_idx   = pick_right ? right_idx : left_idx;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_hole      = r_hole;
        n_key       = r_key;
        n_child     = r_child;
        n_rv        = r_rv;
        n_min       = r_min;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        ram_waddr   = r_hole;
        ram_wdata   = r_key;
        ram_raddr   = r_hole;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            mhpq_pkg::ST_IDLE: begin
                if (s_accept) begin
                    n_state = mhpq_pkg::ST_DONE;
                    if (mhpq_pkg::t_op'(i_s_axis_tuser) == mhpq_pkg::OP_INSERT) begin
                        n_min = '0;
                        if (r_count == CW'(mhpq_pkg::DEPTH)) begin
                            n_status = mhpq_pkg::STAT_FULL;
                        end else begin
                            n_status = mhpq_pkg::STAT_OK;
                            n_key    = i_s_axis_tdata[KW-1:0];
                            n_hole   = IW'(r_count);
                            n_count  = r_count + CW'(1);
                            n_state  = (r_count == '0) ? mhpq_pkg::ST_WR
                                                       : mhpq_pkg::ST_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = mhpq_pkg::STAT_EMPTY;
                            n_min    = '1;
                        end else begin
                            n_status = mhpq_pkg::STAT_OK;
                            n_count  = r_count - CW'(1);
                            n_state  = mhpq_pkg::ST_EX_ROOT;
                        end
                    end
                end
            end
            mhpq_pkg::ST_UP_RD: begin
                ram_raddr = parent_idx;
                n_state   = mhpq_pkg::ST_UP_CMP;
            end
            mhpq_pkg::ST_UP_CMP: begin
                if ($signed(r_key) < $signed(ram_rdata)) begin
                    // parent moves down into the hole
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    n_hole    = parent_idx;
                    n_state   = (parent_idx == '0) ? mhpq_pkg::ST_WR
                                                   : mhpq_pkg::ST_UP_RD;
                end else begin
                    n_state = mhpq_pkg::ST_WR;
                end
            end
            mhpq_pkg::ST_EX_ROOT: begin
                ram_raddr = '0;
                n_state   = mhpq_pkg::ST_EX_LAST;
            end
            mhpq_pkg::ST_EX_LAST: begin
                n_min     = ram_rdata;
                ram_raddr = IW'(r_count);
                n_state   = mhpq_pkg::ST_EX_KEY;
            end
            mhpq_pkg::ST_EX_KEY: begin
                n_key   = ram_rdata;
                n_hole  = '0;
                n_state = (r_count == '0) ? mhpq_pkg::ST_DONE : mhpq_pkg::ST_DN_L;
            end
            mhpq_pkg::ST_DN_L: begin
                ram_raddr = left_idx[IW-1:0];
                n_state   = (left_idx < count_ext) ? mhpq_pkg::ST_DN_R
                                                   : mhpq_pkg::ST_WR;
            end
            mhpq_pkg::ST_DN_R: begin
                n_child   = ram_rdata;
                ram_raddr = right_idx[IW-1:0];
                n_rv      = (right_idx < count_ext);
                n_state   = mhpq_pkg::ST_DN_CMP;
            end
            mhpq_pkg::ST_DN_CMP: begin
                if ($signed(best_key) < $signed(r_key)) begin
                    // smaller child moves up into the hole
                    ram_we    = 1'b1;
                    ram_wdata = best_key;
                    n_hole    = best_idx[IW-1:0];
                    n_state   = mhpq_pkg::ST_DN_L;
                end else begin
                    n_state = mhpq_pkg::ST_WR;
                end
            end
            mhpq_pkg::ST_WR: begin
                ram_we  = 1'b1;
                n_state = mhpq_pkg::ST_DONE;
            end
            mhpq_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = mhpq_pkg::OUT_DATA_W'({mhpq_pkg::OCC_W'(r_count),
                                                         r_status, r_min});
                    n_state     = mhpq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mhpq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mhpq_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hole     <= n_hole;
        r_key      <= n_key;
        r_child    <= n_child;
        r_rv       <= n_rv;
        r_min      <= n_min;
        r_status   <= n_status;
        r_out_data <= n_out_data;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        HW'(r_count) <= HW'(mhpq_pkg::DEPTH))
        else $error("entry count above depth");

    a_write_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (HW'(ram_waddr) < count_ext))
        else $error("heap write outside the held entries");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && (mhpq_pkg::t_op'(i_s_axis_tuser) == mhpq_pkg::OP_INSERT)
            && (r_count != CW'(mhpq_pkg::DEPTH)))
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the count");

    a_up_not_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mhpq_pkg::ST_UP_CMP) |-> (r_hole != '0))
        else $error("sift-up compare at the root");

    a_done_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mhpq_pkg::ST_DONE && !out_free) |=> (r_state == mhpq_pkg::ST_DONE))
        else $error("result dropped while output register busy");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for min_heap_priority_queue: it drives insert and
// extract-min items with random idling, predicts each result and checks it.
// Depends on mhpq_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_top;
    import mhpq_pkg::*;

    typedef logic signed [KEY_WIDTH-1:0] key_t;

    typedef struct packed {
        key_t             min_key;
        t_status          status;
        logic [OCC_W-1:0] occupancy;
    } heap_result_t;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  s_valid = 1'b0;
    logic [IN_DATA_W-1:0]  s_data  = '0;
    logic                  s_user  = 1'b0;
    logic                  s_ready;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OUT_DATA_W-1:0] m_data;

    // predictor state
    key_t heap_mem [DEPTH];
    int   heap_cnt = 0;

    heap_result_t expected_q [$];
    int  errors     = 0;
    bit  no_idle    = 1'b0;
    int  rx_hold    = 0;
    int  quiet_cnt  = 0;

    min_heap_priority_queue dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Apply one item to the predicted heap and return its expected result.
    function automatic heap_result_t heap_apply(input t_op op, input key_t key);
        heap_result_t r;
        int   i;
        int   par;
        int   lc;
        int   rc;
        int   best;
        key_t tmp;
        r.min_key = '0;
        r.status  = STAT_OK;
        if (op == OP_INSERT) begin
            if (heap_cnt >= DEPTH) begin
                r.status = STAT_FULL;
            end else begin
                i = heap_cnt;
                heap_mem[i] = key;
                heap_cnt++;
                // climb while strictly smaller than the parent
                while (i != 0) begin
                    par = (i - 1) / 2;
                    if (!(heap_mem[i] < heap_mem[par]))
                        break;
                    tmp = heap_mem[i];
                    heap_mem[i] = heap_mem[par];
                    heap_mem[par] = tmp;
                    i = par;
                end
            end
        end else if (heap_cnt == 0) begin
            r.status  = STAT_EMPTY;
            r.min_key = '1;
        end else begin
            r.min_key = heap_mem[0];
            heap_cnt--;
            heap_mem[0] = heap_mem[heap_cnt];
            i = 0;
            // descend toward the strictly smaller child, left wins a tie
            forever begin
                best = i;
                lc = 2 * i + 1;
                rc = 2 * i + 2;
                if (lc < heap_cnt && heap_mem[lc] < heap_mem[best])
                    best = lc;
                if (rc < heap_cnt && heap_mem[rc] < heap_mem[best])
                    best = rc;
                if (best == i)
                    break;
                tmp = heap_mem[i];
                heap_mem[i] = heap_mem[best];
                heap_mem[best] = tmp;
                i = best;
            end
        end
        r.occupancy = OCC_W'(heap_cnt);
        return r;
    endfunction

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic send_item(input t_op op, input key_t key);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= key;
        do @(posedge i_clk); while (!s_ready);
        expected_q.push_back(heap_apply(op, key));
    endtask

    function automatic key_t pick_key(input bit narrow);
        int r;
        if (narrow)
            return key_t'($urandom_range(0, 15)) - key_t'(8);
        r = $urandom_range(0, 99);
        case (r % 4)
            0: if (r < 8) return key_t'(32'h7FFF_FFFF);
            1: if (r < 8) return key_t'(32'h8000_0000);
            2: if (r < 8) return key_t'(0);
            default: if (r < 8) return key_t'(-1);
        endcase
        return key_t'($urandom);
    endfunction

    task automatic run_mix(input int n, input int insert_pct, input bit narrow);
        t_op op;
        for (int k = 0; k < n; k++) begin
            op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_EXTRACT;
            send_item(op, pick_key(narrow));
        end
    endtask

    // extremes, ties and extracts on an empty queue
    task automatic test_directed();
        send_item(OP_EXTRACT, key_t'(32'h7FFF_FFFF));
        send_item(OP_EXTRACT, key_t'(32'h8000_0000));
        send_item(OP_INSERT, key_t'(5));
        send_item(OP_INSERT, key_t'(-1));
        send_item(OP_INSERT, key_t'(32'h7FFF_FFFF));
        send_item(OP_INSERT, key_t'(32'h8000_0000));
        send_item(OP_INSERT, key_t'(0));
        send_item(OP_INSERT, key_t'(5));
        send_item(OP_INSERT, key_t'(5));
        send_item(OP_INSERT, key_t'(-1));
        send_item(OP_INSERT, key_t'(1));
        send_item(OP_INSERT, key_t'(32'h8000_0000));
        repeat (11) send_item(OP_EXTRACT, key_t'($urandom));
    endtask

    // fill to capacity, push refused inserts, then drain past empty
    task automatic test_full_store();
        while (heap_cnt < DEPTH)
            send_item(OP_INSERT, pick_key(1'b0));
        repeat (3) send_item(OP_INSERT, pick_key(1'b0));
        send_item(OP_EXTRACT, key_t'($urandom));
        send_item(OP_INSERT, key_t'(32'h8000_0000));
        send_item(OP_INSERT, pick_key(1'b0));
        repeat (DEPTH + 4) send_item(OP_EXTRACT, key_t'($urandom));
    endtask

    task automatic test_random_mix();
        run_mix(400, 50, 1'b0);
        run_mix(300, 70, 1'b0);
        run_mix(250, 55, 1'b1);
        no_idle = 1'b1;
        run_mix(150, 60, 1'b0);
        no_idle = 1'b0;
        run_mix(200, 35, 1'b0);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_store();
        test_random_mix();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("[min_heap_priority_queue] OK");
        end else begin
            $display("[min_heap_priority_queue] ERROR");
        end
        $finish;
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= 1'b0;
        end else begin : pick_stall
            int g;
            g = idle_len();
            if (g == 0) begin
                m_ready <= 1'b1;
            end else begin
                rx_hold <= g - 1;
                m_ready <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        heap_result_t want;
        if (i_rst_n && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result item, expected none, actual %h",
                         $time, m_data);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (m_data[31:0] !== want.min_key) begin
                    $display("%0t: min_key expected %0d actual %0d", $time,
                             want.min_key, $signed(m_data[31:0]));
                    errors++;
                end
                if (m_data[33:32] !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, m_data[33:32]);
                    errors++;
                end
                if (m_data[41:34] !== want.occupancy) begin
                    $display("%0t: occupancy expected %0d actual %0d", $time,
                             want.occupancy, m_data[41:34]);
                    errors++;
                end
                if (m_data[OUT_DATA_W-1:42] !== '0) begin
                    $display("%0t: padding expected 0 actual %h", $time,
                             m_data[OUT_DATA_W-1:42]);
                    errors++;
                end
            end
        end
    end

    // stall detector: cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cnt <= 0;
        end else if (quiet_cnt >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("[min_heap_priority_queue] ERROR");
            $finish;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
        end
    end

endmodule

@@ files.f @@
rtl/mhpq_pkg.sv
rtl/mhpq_ram.sv
rtl/min_heap_priority_queue.sv
verif/tb_top.sv
